>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the convolution block.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, muted while reset is held.
`define C2D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check that also holds while reset is held.
`define C2D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/c2d_pkg.sv
// Shared types and constants of the 2-D convolution block.
// Used by the stream interface users and the top level; depends on nothing.
package c2d_pkg;

  // Item actions.
  typedef enum logic [1:0] {
    ACT_LOAD_SAMPLE = 2'd0,
    ACT_LOAD_WEIGHT = 2'd1,
    ACT_LOAD_MAP    = 2'd2,
    ACT_COMPUTE     = 2'd3
  } c2d_action_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IW = 4;
  localparam int unsigned CFG_DW = 16;
  localparam logic [CFG_IW-1:0] CFG_IN_WIDTH    = 4'd0;
  localparam logic [CFG_IW-1:0] CFG_IN_HEIGHT   = 4'd1;
  localparam logic [CFG_IW-1:0] CFG_IN_CHANNELS = 4'd2;
  localparam logic [CFG_IW-1:0] CFG_OUT_MAPS    = 4'd3;
  localparam logic [CFG_IW-1:0] CFG_STRIDES     = 4'd4;
  localparam logic [CFG_IW-1:0] CFG_PADS_START  = 4'd5;
  localparam logic [CFG_IW-1:0] CFG_PADS_END    = 4'd6;
  localparam logic [CFG_IW-1:0] CFG_ALPHA_SCALE = 4'd7;

  // Signed coordinate width; covers image sizes up to 1024 plus stride reach.
  localparam int unsigned COORD_W = 12;

  typedef struct packed {
    c2d_action_e        action;
    logic [5:0]         pos_x;
    logic [5:0]         pos_y;
    logic [3:0]         channel;
    logic [3:0]         out_map;
    logic signed [15:0] sample_value;
    logic               connected;
  } c2d_in_t;

  typedef struct packed {
    logic [5:0]         out_x;
    logic [5:0]         out_y;
    logic [3:0]         map_index;
    logic signed [15:0] result_value;
    logic               in_range;
    logic               saturated;
  } c2d_out_t;

endpackage

>>> hw/rtl/c2d_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
// The payload type is chosen per instance; no package dependency.
interface c2d_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/conv2d_forward_mac.sv
// Strided, padded 2-D convolution engine with a channel connection map.
// Uses c2d_pkg, c2d_stream_if and assert_macros.svh.
//
// Load items (samples, weights, map bits) are taken in the idle state and do
// not hold off the input. A compute item whose position lies inside the output
// holds off the input until its result is placed in the output register. The
// engine does one multiply-accumulate per cycle, which is set by the single read
// port of the sample and weight memories. On top of the taps come the range
// check, a pipeline drain, the alpha scale split over two partial products, and
// the round and saturate step. With in_channels at zero the taps and the drain
// are skipped. An out-of-range compute item goes from the range check straight
// to the output step. The output step waits while the output register still
// holds an earlier result that has not been taken. One item is in work at a
// time; a finished result waits in an output register while the next item is
// taken. No clearing pass is needed after reset.
`include "assert_macros.svh"

module conv2d_forward_mac #(
  parameter int unsigned MAX_WIDTH    = 64,
  parameter int unsigned MAX_HEIGHT   = 64,
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned MAX_MAPS     = 16,
  parameter int unsigned KERNEL_W     = 3,
  parameter int unsigned KERNEL_H     = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [c2d_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [c2d_pkg::CFG_DW-1:0]    cfg_wdata_i,
  c2d_stream_if.sink                    in_if,
  c2d_stream_if.source                  out_if
);
  import c2d_pkg::*;

  localparam int unsigned IN_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned W_DEPTH  = MAX_MAPS * MAX_CHANNELS * KERNEL_H * KERNEL_W;
  localparam int unsigned M_DEPTH  = MAX_MAPS * MAX_CHANNELS;
  localparam int unsigned IAW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam int unsigned WAW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int unsigned MAW = (M_DEPTH > 1) ? $clog2(M_DEPTH) : 1;
  localparam int unsigned CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned KXW = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;
  localparam int unsigned KYW = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
  localparam int unsigned NCW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned NMW = $clog2(MAX_MAPS + 1);
  localparam int unsigned TAPS = MAX_CHANNELS * KERNEL_H * KERNEL_W;
  localparam int unsigned AW  = 32 + $clog2(TAPS + 1);
  localparam int unsigned LOW = AW / 2;
  localparam int unsigned HIW = AW - LOW;
  localparam int unsigned PW  = AW + 17;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_RUN, ST_DRAIN, ST_SCALE_LO, ST_SCALE_HI, ST_FINISH
  } state_e;

  // Configuration registers.
  logic [6:0]  in_width_q, in_height_q;
  logic [4:0]  in_channels_q, out_maps_q;
  logic [7:0]  strides_q, pads_start_q, pads_end_q;
  logic [15:0] alpha_q;

  state_e      state_q;
  logic        v1_q, v2_q;
  logic [CHW-1:0] c_q;
  logic [KYW-1:0] ky_q;
  logic [KXW-1:0] kx_q;
  logic [5:0]  px_q, py_q;
  logic [3:0]  om_q;
  logic        inr_q;
  logic signed [COORD_W-1:0] bx_q, by_q;
  logic [M_DEPTH-1:0] map_vld_q;
  logic        out_valid_q;
  c2d_out_t    out_q;

  // Datapath registers.
  logic signed [15:0] w_rd_q, x_rd_q;
  logic        m_rd_q, mv_rd_q, ok1_q;
  logic signed [31:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [LOW+15:0] plo_q;
  logic signed [HIW+16:0] phi_q;

  // Memories.
  logic signed [15:0] in_mem   [IN_DEPTH];
  logic signed [15:0] w_mem    [W_DEPTH];
  logic               map_mem  [M_DEPTH];

  // Effective configuration.
  logic [COORD_W-1:0] w_eff, h_eff;
  logic [NCW-1:0] nc_eff;
  logic [NMW-1:0] nm_eff;
  logic [3:0] sx, sy;
  assign w_eff  = (32'(in_width_q) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH)
                                               : COORD_W'(in_width_q);
  assign h_eff  = (32'(in_height_q) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT)
                                                 : COORD_W'(in_height_q);
  assign nc_eff = (32'(in_channels_q) > MAX_CHANNELS) ? NCW'(MAX_CHANNELS)
                                                     : NCW'(in_channels_q);
  assign nm_eff = (32'(out_maps_q) > MAX_MAPS) ? NMW'(MAX_MAPS) : NMW'(out_maps_q);
  assign sx = (strides_q[3:0] == 4'd0) ? 4'd1 : strides_q[3:0];
  assign sy = (strides_q[7:4] == 4'd0) ? 4'd1 : strides_q[7:4];

  // Input transfer and load decode.
  c2d_in_t it;
  logic    in_fire, ld_in, ld_w, ld_m;
  assign it       = in_if.data;
  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire  = in_if.valid && in_if.ready;
  assign ld_in = in_fire && (it.action == ACT_LOAD_SAMPLE) && (32'(it.pos_x) < MAX_WIDTH)
                 && (32'(it.pos_y) < MAX_HEIGHT) && (32'(it.channel) < MAX_CHANNELS);
  assign ld_w  = in_fire && (it.action == ACT_LOAD_WEIGHT) && (32'(it.pos_x) < KERNEL_W)
                 && (32'(it.pos_y) < KERNEL_H) && (32'(it.channel) < MAX_CHANNELS)
                 && (32'(it.out_map) < MAX_MAPS);
  assign ld_m  = in_fire && (it.action == ACT_LOAD_MAP) && (32'(it.channel) < MAX_CHANNELS)
                 && (32'(it.out_map) < MAX_MAPS);

  logic [IAW-1:0] ld_iaddr;
  logic [WAW-1:0] ld_waddr;
  logic [MAW-1:0] ld_maddr;
  assign ld_iaddr = IAW'(IAW'(it.channel) * IAW'(MAX_HEIGHT * MAX_WIDTH)
                    + IAW'(it.pos_y) * IAW'(MAX_WIDTH) + IAW'(it.pos_x));
  assign ld_waddr = WAW'(((WAW'(it.out_map) * WAW'(MAX_CHANNELS) + WAW'(it.channel))
                    * WAW'(KERNEL_H) + WAW'(it.pos_y)) * WAW'(KERNEL_W) + WAW'(it.pos_x));
  assign ld_maddr = MAW'(MAW'(it.out_map) * MAW'(MAX_CHANNELS) + MAW'(it.channel));

  // Range check of a compute item: px < out_w is px*sx + KERNEL_W <= ext.
  logic [COORD_W-1:0] pxs, pys, ext_x, ext_y;
  logic inr_d;
  assign pxs   = COORD_W'(px_q) * COORD_W'(sx);
  assign pys   = COORD_W'(py_q) * COORD_W'(sy);
  assign ext_x = w_eff + COORD_W'(pads_start_q[3:0]) + COORD_W'(pads_end_q[3:0]);
  assign ext_y = h_eff + COORD_W'(pads_start_q[7:4]) + COORD_W'(pads_end_q[7:4]);
  assign inr_d = (32'(om_q) < 32'(nm_eff))
                 && (ext_x >= COORD_W'(KERNEL_W)) && (pxs + COORD_W'(KERNEL_W) <= ext_x)
                 && (ext_y >= COORD_W'(KERNEL_H)) && (pys + COORD_W'(KERNEL_H) <= ext_y);

  // Tap address generation.
  logic signed [COORD_W-1:0] ix, iy;
  logic tap_ok;
  logic [IAW-1:0] rd_iaddr;
  logic [WAW-1:0] rd_waddr;
  logic [MAW-1:0] rd_maddr;
  logic c_last, ky_last, kx_last;
  assign ix = bx_q + $signed(COORD_W'(kx_q));
  assign iy = by_q + $signed(COORD_W'(ky_q));
  assign tap_ok = !ix[COORD_W-1] && !iy[COORD_W-1]
                  && ($unsigned(ix) < w_eff) && ($unsigned(iy) < h_eff);
  assign rd_iaddr = IAW'(IAW'(c_q) * IAW'(MAX_HEIGHT * MAX_WIDTH)
                    + IAW'($unsigned(iy)) * IAW'(MAX_WIDTH) + IAW'($unsigned(ix)));
  assign rd_waddr = WAW'(((WAW'(om_q) * WAW'(MAX_CHANNELS) + WAW'(c_q))
                    * WAW'(KERNEL_H) + WAW'(ky_q)) * WAW'(KERNEL_W) + WAW'(kx_q));
  assign rd_maddr = MAW'(MAW'(om_q) * MAW'(MAX_CHANNELS) + MAW'(c_q));
  assign kx_last = (32'(kx_q) == KERNEL_W - 1);
  assign ky_last = (32'(ky_q) == KERNEL_H - 1);
  assign c_last  = (32'(c_q) + 1 == 32'(nc_eff));

  // Scale, round half up and saturate.
  logic signed [PW-1:0]  p_full, v_rnd;
  logic signed [PW-23:0] res_w;
  logic sat_hi, sat_lo, out_free;
  c2d_out_t res_d;
  assign p_full = (PW'(phi_q) <<< LOW) + $signed(PW'(plo_q));
  assign v_rnd  = p_full + $signed(PW'(1) <<< 21);
  assign res_w  = v_rnd[PW-1:22];
  assign sat_hi = res_w > $signed((PW-22)'(32767));
  assign sat_lo = res_w < -$signed((PW-22)'(32768));
  assign out_free = !out_valid_q || out_if.ready;

  always_comb begin
    res_d.out_x     = px_q;
    res_d.out_y     = py_q;
    res_d.map_index = om_q;
    res_d.in_range  = inr_q;
    res_d.saturated = inr_q && (sat_hi || sat_lo);
    if (!inr_q) begin
      res_d.result_value = '0;
    end else if (sat_hi) begin
      res_d.result_value = 16'sh7fff;
    end else if (sat_lo) begin
      res_d.result_value = 16'sh8000;
    end else begin
      res_d.result_value = res_w[15:0];
    end
  end

  // Control state machine, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      in_width_q    <= 7'd64;
      in_height_q   <= 7'd64;
      in_channels_q <= 5'd16;
      out_maps_q    <= 5'd16;
      strides_q     <= 8'h11;
      pads_start_q  <= 8'h00;
      pads_end_q    <= 8'h00;
      alpha_q       <= 16'd16384;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      c_q           <= '0;
      ky_q          <= '0;
      kx_q          <= '0;
      map_vld_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_IN_WIDTH:    in_width_q    <= cfg_wdata_i[6:0];
          CFG_IN_HEIGHT:   in_height_q   <= cfg_wdata_i[6:0];
          CFG_IN_CHANNELS: in_channels_q <= cfg_wdata_i[4:0];
          CFG_OUT_MAPS:    out_maps_q    <= cfg_wdata_i[4:0];
          CFG_STRIDES:     strides_q     <= cfg_wdata_i[7:0];
          CFG_PADS_START:  pads_start_q  <= cfg_wdata_i[7:0];
          CFG_PADS_END:    pads_end_q    <= cfg_wdata_i[7:0];
          CFG_ALPHA_SCALE: alpha_q       <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (ld_m) begin
        map_vld_q[ld_maddr] <= 1'b1;
      end
      // A result taken in the output cycle is replaced below, not cleared here.
      if (out_valid_q && out_if.ready && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      v2_q <= v1_q;
      v1_q <= (state_q == ST_RUN);
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && it.action == ACT_COMPUTE) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          c_q  <= '0;
          ky_q <= '0;
          kx_q <= '0;
          if (!inr_d) begin
            state_q <= ST_FINISH;
          end else if (nc_eff == '0) begin
            state_q <= ST_SCALE_LO;
          end else begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!kx_last) begin
            kx_q <= kx_q + 1'b1;
          end else begin
            kx_q <= '0;
            if (!ky_last) begin
              ky_q <= ky_q + 1'b1;
            end else begin
              ky_q <= '0;
              c_q  <= c_q + 1'b1;
              if (c_last) begin
                state_q <= ST_DRAIN;
              end
            end
          end
        end
        ST_DRAIN: begin
          if (!v1_q && !v2_q) begin
            state_q <= ST_SCALE_LO;
          end
        end
        ST_SCALE_LO: state_q <= ST_SCALE_HI;
        ST_SCALE_HI: state_q <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  // Sample memory: one write port for loads, one registered read for taps.
  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      in_mem[ld_iaddr] <= it.sample_value;
    end
    x_rd_q <= in_mem[rd_iaddr];
  end

  // Weight memory.
  always_ff @(posedge clk_i) begin
    if (ld_w) begin
      w_mem[ld_waddr] <= it.sample_value;
    end
    w_rd_q <= w_mem[rd_waddr];
  end

  // Connection map memory; entries never written read as connected.
  always_ff @(posedge clk_i) begin
    if (ld_m) begin
      map_mem[ld_maddr] <= it.connected;
    end
    m_rd_q <= map_mem[rd_maddr];
  end

  // Item latch, multiply-accumulate pipeline, alpha scaling and result register.
  always_ff @(posedge clk_i) begin
    mv_rd_q <= map_vld_q[rd_maddr];
    ok1_q   <= tap_ok;
    prod_q  <= (v1_q && ok1_q && (!mv_rd_q || m_rd_q)) ? w_rd_q * x_rd_q : 32'sd0;
    if (in_fire && it.action == ACT_COMPUTE) begin
      px_q <= it.pos_x;
      py_q <= it.pos_y;
      om_q <= it.out_map;
    end
    if (state_q == ST_CHECK) begin
      inr_q <= inr_d;
      bx_q  <= $signed(pxs) - $signed(COORD_W'(pads_start_q[3:0]));
      by_q  <= $signed(pys) - $signed(COORD_W'(pads_start_q[7:4]));
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + AW'(prod_q);
    end
    if (state_q == ST_SCALE_LO) begin
      plo_q <= (LOW+16)'(acc_q[LOW-1:0]) * (LOW+16)'(alpha_q);
    end
    if (state_q == ST_SCALE_HI) begin
      phi_q <= (HIW+17)'($signed(acc_q[AW-1:LOW])) * $signed((HIW+17)'(alpha_q));
    end
    if (state_q == ST_FINISH && out_free) begin
      out_q <= res_d;
    end
  end

  // Checks.
  `C2D_ASSERT(a_result_from_finish,
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "result without a finished item")
  `C2D_ASSERT(a_acc_clear_at_run,
    (state_q == ST_RUN && $past(state_q == ST_CHECK)) |-> (acc_q == '0),
    "accumulator not cleared at start of taps")
  `C2D_ASSERT(a_out_of_range_zero,
    (out_valid_q && !out_q.in_range) |-> (out_q.result_value == '0 && !out_q.saturated),
    "out-of-range result not zero")

endmodule

>>> sim/tb_conv2d_forward_mac.sv
// Self-checking testbench for the conv2d_forward_mac convolution engine.
// Depends on c2d_pkg, c2d_stream_if and the RTL top level; needs no files.
`timescale 1ns / 1ps

module tb_conv2d_forward_mac;
  import c2d_pkg::*;

  typedef logic signed [15:0] q88_t;

  // Mirror of the engine: stores, connection map, registers, and the queue of
  // results still owed by the engine.
  class conv_scoreboard;
    q88_t     samples[16][64][64];
    bit       sample_set[16][64][64];
    q88_t     weights[16][16][3][3];
    bit       weight_set[16][16][3][3];
    bit       conn[16][16];
    bit [15:0] regs[8];
    c2d_out_t owed[$];
    int       errors;

    function new();
      foreach (conn[m, c]) conn[m][c] = 1'b1;
      regs = '{64, 64, 16, 16, 'h11, 0, 0, 16384};
      errors = 0;
    endfunction

    function void write_reg(int idx, bit [15:0] val);
      bit [15:0] mask[8];
      mask = '{'h7f, 'h7f, 'h1f, 'h1f, 'hff, 'hff, 'hff, 'hffff};
      if (idx < 8) regs[idx] = val & mask[idx];
    endfunction

    function int clamp(int v, int lim);
      return (v > lim) ? lim : v;
    endfunction

    function int stride(int shift);
      int s;
      s = (regs[CFG_STRIDES] >> shift) & 15;
      return (s == 0) ? 1 : s;
    endfunction

    // Output length along one axis after padding and stride.
    function int out_len(int dim, int pa, int pb, int k, int s);
      int ext;
      ext = dim + pa + pb;
      return (ext < k) ? 0 : (ext - k) / s + 1;
    endfunction

    function int out_w();
      return out_len(clamp(regs[CFG_IN_WIDTH], 64), regs[CFG_PADS_START] & 15,
                     regs[CFG_PADS_END] & 15, 3, stride(0));
    endfunction

    function int out_h();
      return out_len(clamp(regs[CFG_IN_HEIGHT], 64), regs[CFG_PADS_START] >> 4,
                     regs[CFG_PADS_END] >> 4, 3, stride(4));
    endfunction

    // Weighted sum of one compute item; known drops when an unwritten entry is read.
    function void accumulate(c2d_in_t it, output longint acc, output bit known,
                             output bit inr);
      int w, h, nc, nm, ix, iy;
      w = clamp(regs[CFG_IN_WIDTH], 64);
      h = clamp(regs[CFG_IN_HEIGHT], 64);
      nc = clamp(regs[CFG_IN_CHANNELS], 16);
      nm = clamp(regs[CFG_OUT_MAPS], 16);
      acc = 0;
      known = 1'b1;
      inr = (it.out_map < nm) && (it.pos_x < out_w()) && (it.pos_y < out_h());
      if (!inr) return;
      for (int c = 0; c < nc; c++) begin
        if (!conn[it.out_map][c]) continue;
        for (int ky = 0; ky < 3; ky++) begin
          iy = it.pos_y * stride(4) + ky - (regs[CFG_PADS_START] >> 4);
          if (iy < 0 || iy >= h) continue;
          for (int kx = 0; kx < 3; kx++) begin
            ix = it.pos_x * stride(0) + kx - (regs[CFG_PADS_START] & 15);
            if (ix < 0 || ix >= w) continue;
            if (!weight_set[it.out_map][c][ky][kx] || !sample_set[c][iy][ix])
              known = 1'b0;
            acc += longint'(weights[it.out_map][c][ky][kx]) *
                   longint'(samples[c][iy][ix]);
          end
        end
      end
    endfunction

    function bit reads_known(c2d_in_t it);
      longint acc;
      bit known, inr;
      accumulate(it, acc, known, inr);
      return known;
    endfunction

    // Applies one accepted input transfer and queues the result it owes.
    function void note_input(c2d_in_t it);
      longint acc, scaled;
      bit known, inr;
      c2d_out_t r;
      case (it.action)
        ACT_LOAD_SAMPLE: begin
          samples[it.channel][it.pos_y][it.pos_x] = it.sample_value;
          sample_set[it.channel][it.pos_y][it.pos_x] = 1'b1;
        end
        ACT_LOAD_WEIGHT: begin
          if (it.pos_x < 3 && it.pos_y < 3) begin
            weights[it.out_map][it.channel][it.pos_y][it.pos_x] = it.sample_value;
            weight_set[it.out_map][it.channel][it.pos_y][it.pos_x] = 1'b1;
          end
        end
        ACT_LOAD_MAP: conn[it.out_map][it.channel] = it.connected;
        default: begin
          accumulate(it, acc, known, inr);
          r = '0;
          r.out_x = it.pos_x;
          r.out_y = it.pos_y;
          r.map_index = it.out_map;
          r.in_range = inr;
          if (inr) begin
            // Round half up from Q18.30 to Q8.8, then clip to 16 bits.
            scaled = (acc * longint'(regs[CFG_ALPHA_SCALE]) + (64'sd1 <<< 21)) >>> 22;
            if (scaled > 32767) begin
              scaled = 32767;
              r.saturated = 1'b1;
            end else if (scaled < -32768) begin
              scaled = -32768;
              r.saturated = 1'b1;
            end
            r.result_value = q88_t'(scaled);
          end
          owed.push_back(r);
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_result(c2d_out_t got);
      c2d_out_t exp_r;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      exp_r = owed.pop_front();
      if (got.out_x !== exp_r.out_x || got.out_y !== exp_r.out_y ||
          got.map_index !== exp_r.map_index)
        report($sformatf("position got %p want %p", got, exp_r));
      else if (got.result_value !== exp_r.result_value)
        report($sformatf("value at (%0d,%0d) map %0d got %0d want %0d", got.out_x,
                         got.out_y, got.map_index, got.result_value, exp_r.result_value));
      else if (got.in_range !== exp_r.in_range || got.saturated !== exp_r.saturated)
        report($sformatf("flags got %p want %p", got, exp_r));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;

  c2d_stream_if #(.T(c2d_in_t))  in_if ();
  c2d_stream_if #(.T(c2d_out_t)) out_if ();

  conv2d_forward_mac u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if.sink),
    .out_if      (out_if.source)
  );

  conv_scoreboard sb = new();
  int src_idle = 0;
  int snk_stall = 0;
  int hold_left = 0;
  int fill_w, fill_h, fill_maps;

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // Result side: check each transfer, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= snk_stall);
    end
  end

  // Offers one item, with random idle cycles before it, until it is taken.
  task send(c2d_in_t it);
    while ($urandom_range(0, 99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task settle();
    in_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task write_regs(bit [15:0] vals[8]);
    logic [CFG_IW-1:0] idx[8];
    idx = '{CFG_IN_WIDTH, CFG_IN_HEIGHT, CFG_IN_CHANNELS, CFG_OUT_MAPS,
            CFG_STRIDES, CFG_PADS_START, CFG_PADS_END, CFG_ALPHA_SCALE};
    foreach (idx[i]) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function q88_t rand_q88();
    if ($urandom_range(0, 3) == 0) return q88_t'($urandom);
    return q88_t'($urandom_range(0, 1023) - 512);
  endfunction

  function c2d_in_t load_item(c2d_action_e act, int x, int y, int ch, int om, q88_t v);
    c2d_in_t it;
    it = '0;
    it.action = act;
    it.pos_x = 6'(x);
    it.pos_y = 6'(y);
    it.channel = 4'(ch);
    it.out_map = 4'(om);
    it.sample_value = v;
    it.connected = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Writes every sample and weight that computes of this phase are meant to read.
  task fill_stores();
    int nc;
    nc = sb.clamp(sb.regs[CFG_IN_CHANNELS], 16);
    for (int c = 0; c < nc; c++)
      for (int y = 0; y < fill_h; y++)
        for (int x = 0; x < fill_w; x++)
          send(load_item(ACT_LOAD_SAMPLE, x, y, c, 0, rand_q88()));
    for (int m = 0; m < fill_maps; m++)
      for (int c = 0; c < nc; c++)
        for (int k = 0; k < 9; k++)
          send(load_item(ACT_LOAD_WEIGHT, k % 3, k / 3, c, m, rand_q88()));
  endtask

  // Random stream: mostly computes that read only written entries, plus loads.
  function c2d_in_t rand_item();
    c2d_in_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      for (int tries = 0; tries < 20; tries++) begin
        it = load_item(ACT_COMPUTE, 0, 0, $urandom_range(0, 15), 0, q88_t'($urandom));
        if ($urandom_range(0, 7) == 0) begin
          it.pos_x = 6'($urandom_range(0, 63));
          it.pos_y = 6'($urandom_range(0, 63));
        end else begin
          it.pos_x = 6'($urandom_range(0, sb.clamp(sb.out_w(), 63)));
          it.pos_y = 6'($urandom_range(0, sb.clamp(sb.out_h(), 63)));
          it.out_map = 4'($urandom_range(0, sb.clamp(sb.regs[CFG_OUT_MAPS], 15)));
        end
        if (sb.reads_known(it)) return it;
      end
    end
    if (pick < 75 || pick < 60)
      return load_item(ACT_LOAD_SAMPLE, $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 15), $urandom_range(0, 15), rand_q88());
    if (pick < 88)
      return load_item(ACT_LOAD_WEIGHT, $urandom_range(0, 3), $urandom_range(0, 3),
                       $urandom_range(0, 15), $urandom_range(0, 15), rand_q88());
    it = load_item(ACT_LOAD_MAP, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 15), $urandom_range(0, 15), q88_t'($urandom));
    it.connected = ($urandom_range(0, 3) != 0);
    return it;
  endfunction

  task run_phase(bit [15:0] vals[8], int idle, int stall, int fw, int fh, int fm,
                 int n, int hold);
    settle();
    write_regs(vals);
    src_idle = idle;
    snk_stall = stall;
    fill_w = fw;
    fill_h = fh;
    fill_maps = fm;
    fill_stores();
    hold_left = hold;
    repeat (n) send(rand_item());
  endtask

  // Directed start: padding corners, edges, extremes, saturation and ignored loads.
  task directed();
    bit [15:0] vals[8];
    vals = '{4, 4, 1, 2, 'h11, 'h11, 'h11, 16384};
    write_regs(vals);
    fill_w = 4;
    fill_h = 4;
    fill_maps = 2;
    fill_stores();
    send(load_item(ACT_COMPUTE, 0, 0, 0, 0, 0));
    send(load_item(ACT_COMPUTE, 3, 3, 0, 1, 0));
    send(load_item(ACT_COMPUTE, 4, 0, 0, 0, 0));
    send(load_item(ACT_COMPUTE, 0, 4, 0, 0, 0));
    send(load_item(ACT_COMPUTE, 1, 1, 0, 2, 0));
    send(load_item(ACT_COMPUTE, 63, 63, 0, 15, 0));
    send(load_item(ACT_LOAD_WEIGHT, 3, 3, 0, 0, 16'sh1234));
    send(load_item(ACT_LOAD_WEIGHT, 63, 63, 15, 15, 16'sh1234));
    // Drive every weight of map 0 to the positive limit, then one sample to each limit in turn.
    for (int k = 0; k < 9; k++)
      send(load_item(ACT_LOAD_WEIGHT, k % 3, k / 3, 0, 0, 16'sh7fff));
    send(load_item(ACT_LOAD_SAMPLE, 1, 1, 0, 0, 16'sh7fff));
    send(load_item(ACT_COMPUTE, 1, 1, 0, 0, 0));
    send(load_item(ACT_LOAD_SAMPLE, 1, 1, 0, 0, -16'sd32768));
    send(load_item(ACT_COMPUTE, 1, 1, 0, 0, 0));
    begin
      c2d_in_t it;
      it = load_item(ACT_LOAD_MAP, 0, 0, 0, 1, 0);
      it.connected = 1'b0;
      send(it);
    end
    send(load_item(ACT_COMPUTE, 2, 2, 0, 1, 0));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    run_phase('{8, 6, 2, 4, 'h21, 'h01, 'h10, 16384}, 0, 0, 8, 6, 2, 60, 0);
    run_phase('{5, 7, 2, 3, 'h00, 'hff, 'hff, 65535}, 85, 0, 5, 7, 2, 60, 0);
    run_phase('{64, 64, 2, 16, 'hff, 0, 0, 0}, 0, 85, 3, 3, 2, 60, 0);
    run_phase('{127, 0, 31, 31, 'h1f, 'h0f, 'hf0, 1}, 21, 21, 0, 0, 0, 60, 0);
    run_phase('{16, 16, 0, 1, 'h12, 'h22, 0, 32768}, 0, 0, 0, 0, 0, 80, 600);
    run_phase('{6, 6, 2, 16, 'h11, 0, 0, 16384}, 21, 21, 6, 6, 2, 60, 0);
    settle();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit well beyond the slowest legal run.
  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
